[rtl/text_console_writer_unit_assert.svh]
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shorthand for clocked, reset-qualified property checks.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH

// check the consequent in the same cycle as the antecedent
`define TCW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("text console writer check failed");

// check the consequent in the cycle after the antecedent
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text console writer check failed");

`endif

[rtl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, word types, command codes and shared helpers.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int FILL_W = $clog2(COLUMNS + 1);
  localparam int POS_W  = 13;

  localparam int RECIP_SHIFT = 18;
  localparam int RECIP_MUL   = (1 << RECIP_SHIFT) / COLUMNS + 1;
  localparam int RECIP_W     = RECIP_SHIFT + ROW_W;

  localparam int Q_DEPTH = 2;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] ATTR_RESET = 8'h07;

  localparam logic [2:0] CMD_PUT     = 3'd0;
  localparam logic [2:0] CMD_NEWLINE = 3'd1;
  localparam logic [2:0] CMD_RETURN  = 3'd2;
  localparam logic [2:0] CMD_CLEAR   = 3'd3;
  localparam logic [2:0] CMD_READ    = 3'd4;
  localparam logic [2:0] CMD_NOP     = 3'd5;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_word_t;

  typedef struct packed {
    logic [10:0] cursor_position;
    logic [15:0] cell_data;
    logic        scrolled;
  } out_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } cmd_t;

  function automatic logic [10:0] cursor_pos(input logic [ROW_W-1:0] row,
                                             input logic [COL_W-1:0] col);
    logic [POS_W-1:0] p;
    p = POS_W'(row) * POS_W'(COLUMNS) + POS_W'(col);
    return p[10:0];
  endfunction

endpackage

[rtl/tcw_front.sv]
// ----------------------------------------------------------------------------
// Text console writer front end
// Accepts input words and classifies them into back-end commands.
// ----------------------------------------------------------------------------
module tcw_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  tcw_pkg::in_word_t in_data,
  output logic             cmd_valid,
  input  logic             cmd_stall,
  output tcw_pkg::cmd_t    cmd_data
);

  logic          vld_r;
  tcw_pkg::cmd_t cmd_r;
  tcw_pkg::cmd_t cmd_nxt;

  always_comb begin
    cmd_nxt.char_code  = in_data.char_code;
    cmd_nxt.cell_index = in_data.cell_index;
    unique case (in_data.operation)
      tcw_pkg::OP_PUT: begin
        if (in_data.char_code == tcw_pkg::CH_NEWLINE) cmd_nxt.kind = tcw_pkg::CMD_NEWLINE;
        else if (in_data.char_code == tcw_pkg::CH_RETURN) cmd_nxt.kind = tcw_pkg::CMD_RETURN;
        else cmd_nxt.kind = tcw_pkg::CMD_PUT;
      end
      tcw_pkg::OP_CLEAR: cmd_nxt.kind = tcw_pkg::CMD_CLEAR;
      tcw_pkg::OP_READ: begin
        if (32'(in_data.cell_index) < 32'(tcw_pkg::CELLS)) cmd_nxt.kind = tcw_pkg::CMD_READ;
        else cmd_nxt.kind = tcw_pkg::CMD_NOP;
      end
      default: cmd_nxt.kind = tcw_pkg::CMD_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!vld_r || !cmd_stall) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign in_stall  = vld_r && cmd_stall;
  assign cmd_valid = vld_r;
  assign cmd_data  = cmd_r;

endmodule

[rtl/tcw_queue.sv]
// ----------------------------------------------------------------------------
// Text console writer command queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module tcw_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_stall,
  input  tcw_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_stall,
  output tcw_pkg::cmd_t pop_data
);

  localparam int PTR_W = $clog2(tcw_pkg::Q_DEPTH);
  localparam int CNT_W = $clog2(tcw_pkg::Q_DEPTH + 1);

  tcw_pkg::cmd_t    slot_r [tcw_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign push_stall = (cnt_r == CNT_W'(tcw_pkg::Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && !push_stall;
  assign do_pop     = pop_valid && !pop_stall;
  assign pop_data   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(tcw_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(tcw_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/tcw_back.sv]
// ----------------------------------------------------------------------------
// Text console writer back end
// Holds the screen store, the cursor and the row map, and executes commands.
// ----------------------------------------------------------------------------
module tcw_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  tcw_pkg::cmd_t      cmd_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tcw_pkg::out_word_t out_data
);

  localparam int COL_W     = tcw_pkg::COL_W;
  localparam int ROW_W     = tcw_pkg::ROW_W;
  localparam int FILL_W    = tcw_pkg::FILL_W;
  localparam int RECIP_W   = tcw_pkg::RECIP_W;
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int MEM_DEPTH = tcw_pkg::ROWS << COL_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_RD     = 2'd2;

  logic [15:0]       mem [MEM_DEPTH];
  logic [15:0]       mem_q_r;

  logic [1:0]        state_r;
  logic [7:0]        attr_r;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic [ROW_W-1:0]  top_r;
  logic [FILL_W-1:0] fill_r [tcw_pkg::ROWS];
  logic [7:0]        battr_r [tcw_pkg::ROWS];
  logic [10:0]       rem_r;
  logic [ROW_W-1:0]  rrow_r;
  logic              hit_r;
  logic [7:0]        hattr_r;
  logic              out_valid_r;
  tcw_pkg::out_word_t out_data_r;

  logic [ROW_W:0]    cur_psum;
  logic [ROW_W-1:0]  cur_prow;
  logic [ROW_W:0]    rd_psum;
  logic [ROW_W-1:0]  rd_prow;
  logic [RECIP_W-1:0] rd_prod;
  logic [ROW_W-1:0]  rd_row;
  logic [10:0]       rd_col;
  logic [ROW_W-1:0]  fill_addr;
  logic [FILL_W-1:0] fill_rd;
  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc;
  logic [FILL_W-1:0] fill_inc;
  logic              out_free;
  logic              take;
  logic [COL_W-1:0]  col_nxt;
  logic [ROW_W-1:0]  row_nxt;
  logic              adv;
  logic              wr_en;
  logic              clr;
  logic              scroll;
  logic              start_rd;

  assign cur_psum = (ROW_W+1)'(top_r) + (ROW_W+1)'(row_r);
  assign cur_prow = (cur_psum >= (ROW_W+1)'(tcw_pkg::ROWS)) ?
                    ROW_W'(cur_psum - (ROW_W+1)'(tcw_pkg::ROWS)) : ROW_W'(cur_psum);
  assign rd_psum  = (ROW_W+1)'(top_r) + (ROW_W+1)'(rrow_r);
  assign rd_prow  = (rd_psum >= (ROW_W+1)'(tcw_pkg::ROWS)) ?
                    ROW_W'(rd_psum - (ROW_W+1)'(tcw_pkg::ROWS)) : ROW_W'(rd_psum);

  assign rd_prod = RECIP_W'(cmd_data.cell_index) * RECIP_W'(tcw_pkg::RECIP_MUL);
  assign rd_row  = rd_prod[tcw_pkg::RECIP_SHIFT +: ROW_W];
  assign rd_col  = cmd_data.cell_index - 11'(rd_row) * 11'(tcw_pkg::COLUMNS);

  assign fill_addr = (state_r == ST_LOOKUP) ? rd_prow : cur_prow;
  assign fill_rd   = fill_r[fill_addr];

  assign col_inc  = (COL_W+1)'(col_r) + 1'b1;
  assign row_inc  = (ROW_W+1)'(row_r) + 1'b1;
  assign fill_inc = FILL_W'(col_inc);
  assign out_free = !out_valid_r || !out_stall;
  assign take     = (state_r == ST_IDLE) && cmd_valid && out_free;
  assign cmd_stall = !take;

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    adv      = 1'b0;
    wr_en    = 1'b0;
    clr      = 1'b0;
    scroll   = 1'b0;
    start_rd = 1'b0;
    if (take) begin
      unique case (cmd_data.kind)
        tcw_pkg::CMD_PUT: begin
          wr_en = 1'b1;
          if (col_inc == (COL_W+1)'(tcw_pkg::COLUMNS)) begin
            col_nxt = '0;
            adv     = 1'b1;
          end else begin
            col_nxt = col_inc[COL_W-1:0];
          end
        end
        tcw_pkg::CMD_NEWLINE: begin
          col_nxt = '0;
          adv     = 1'b1;
        end
        tcw_pkg::CMD_RETURN: col_nxt = '0;
        tcw_pkg::CMD_CLEAR: begin
          clr     = 1'b1;
          col_nxt = '0;
          row_nxt = '0;
        end
        tcw_pkg::CMD_READ: start_rd = 1'b1;
        default: ;
      endcase
      if (adv) begin
        if (row_inc == (ROW_W+1)'(tcw_pkg::ROWS)) begin
          scroll  = 1'b1;
          row_nxt = ROW_W'(tcw_pkg::ROWS - 1);
          col_nxt = '0;
        end else begin
          row_nxt = row_inc[ROW_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      attr_r      <= tcw_pkg::ATTR_RESET;
      col_r       <= '0;
      row_r       <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) attr_r <= cfg_wdata;
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (clr) begin
        top_r <= '0;
      end else if (scroll) begin
        top_r <= (top_r == ROW_W'(tcw_pkg::ROWS - 1)) ? '0 : top_r + 1'b1;
      end
      unique case (state_r)
        ST_IDLE:   if (start_rd) state_r <= ST_LOOKUP;
        ST_LOOKUP: state_r <= ST_RD;
        ST_RD:     if (out_free) state_r <= ST_IDLE;
        default:   state_r <= ST_IDLE;
      endcase
      if ((take && !start_rd) || (state_r == ST_RD && out_free)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tcw_pkg::ROWS; i++) begin
        fill_r[ROW_W'(i)]  <= '0;
        battr_r[ROW_W'(i)] <= tcw_pkg::ATTR_RESET;
      end
    end else if (clr) begin
      for (int i = 0; i < tcw_pkg::ROWS; i++) begin
        fill_r[ROW_W'(i)]  <= '0;
        battr_r[ROW_W'(i)] <= attr_r;
      end
    end else begin
      if (wr_en && (fill_inc > fill_rd)) fill_r[cur_prow] <= fill_inc;
      if (scroll) begin
        fill_r[top_r]  <= '0;
        battr_r[top_r] <= attr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && start_rd) begin
      rem_r  <= rd_col;
      rrow_r <= rd_row;
    end
    if (state_r == ST_LOOKUP) begin
      hit_r   <= (rem_r < 11'(fill_rd));
      hattr_r <= battr_r[rd_prow];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ADDR_W'({cur_prow, col_r})] <= {attr_r, cmd_data.char_code};
    end
    if (state_r == ST_LOOKUP) begin
      mem_q_r <= mem[ADDR_W'({rd_prow, rem_r[COL_W-1:0]})];
    end
  end

  always_ff @(posedge clk) begin
    if (take && !start_rd) begin
      out_data_r.cursor_position <= tcw_pkg::cursor_pos(row_nxt, col_nxt);
      out_data_r.cell_data       <= '0;
      out_data_r.scrolled        <= scroll;
    end else if (state_r == ST_RD && out_free) begin
      out_data_r.cursor_position <= tcw_pkg::cursor_pos(row_r, col_r);
      out_data_r.cell_data       <= hit_r ? mem_q_r : {hattr_r, tcw_pkg::CH_SPACE};
      out_data_r.scrolled        <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/text_console_writer_unit.sv]
// ----------------------------------------------------------------------------
// Text console writer unit
// Put, clear and read words on a text screen with cursor and scrolling.
// ----------------------------------------------------------------------------
// Path: put, clear and unused words pass the front-end register, the queue and
// the result register; reads first pass the row lookup with the screen RAM read.
// Throughput: one word per cycle for non-read words, set by the back end, while
// out_stall is low; a read holds the back end through its lookup and read states.
// Scroll and clear work through per-row fill counts and a row map.
// Reset: synchronous; cursor homes, attribute is 0x07, all rows read blank.
module text_console_writer_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tcw_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tcw_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);

  logic          f_valid;
  logic          f_stall;
  tcw_pkg::cmd_t f_cmd;
  logic          b_valid;
  logic          b_stall;
  tcw_pkg::cmd_t b_cmd;

  tcw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (f_valid),
    .cmd_stall (f_stall),
    .cmd_data  (f_cmd)
  );

  tcw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_stall (f_stall),
    .push_data  (f_cmd),
    .pop_valid  (b_valid),
    .pop_stall  (b_stall),
    .pop_data   (b_cmd)
  );

  tcw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (b_valid),
    .cmd_stall (b_stall),
    .cmd_data  (b_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/tcw_checker.sv]
// ----------------------------------------------------------------------------
// Text console writer checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_console_writer_unit_assert.svh"

module tcw_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input tcw_pkg::out_word_t out_data
);

  `TCW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  `TCW_ASSERT_NOW(a_pos_range, clk, rst_n, out_valid, 32'(out_data.cursor_position) < 32'(tcw_pkg::CELLS))
  `TCW_ASSERT_NOW(a_scroll_pos, clk, rst_n, out_valid && out_data.scrolled, out_data.cursor_position == 11'((tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS))
  `TCW_ASSERT_NOW(a_scroll_nodata, clk, rst_n, out_valid && out_data.scrolled, out_data.cell_data == 16'h0000)

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[test/tb.sv]
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives put, clear, read and unused words into the console engine, predicts
// each result word from a shadow screen and cursor, and checks the results in
// order while the input idles and the result channel stalls at random.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ADDR_SPAN = 2048;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_RHYTHM, STALL_RARE} stall_mode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  tcw_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  tcw_pkg::out_word_t out_data;
  logic               cfg_we = 1'b0;
  logic [7:0]         cfg_wdata = '0;

  logic [15:0]        shadow_cells [tcw_pkg::CELLS];
  logic [7:0]         attr_reg;
  int                 row_now;
  int                 col_now;
  tcw_pkg::out_word_t expected_words [$];
  int                 mismatches = 0;
  int                 burst_left = 0;
  int                 stall_tick = 0;

  text_console_writer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic tcw_pkg::in_word_t make_word(input logic [1:0] op,
                                                  input logic [7:0] ch,
                                                  input logic [10:0] idx);
    tcw_pkg::in_word_t w;
    w.operation = op;
    w.char_code = ch;
    w.cell_index = idx;
    return w;
  endfunction

  function automatic tcw_pkg::out_word_t console_result(input tcw_pkg::in_word_t w);
    tcw_pkg::out_word_t r;
    logic [15:0]        blank;
    int                 pos;
    r = '0;
    blank = {attr_reg, tcw_pkg::CH_SPACE};
    case (w.operation)
      tcw_pkg::OP_PUT: begin
        if (w.char_code == tcw_pkg::CH_NEWLINE) begin
          col_now = 0;
          row_now++;
        end else if (w.char_code == tcw_pkg::CH_RETURN) begin
          col_now = 0;
        end else begin
          shadow_cells[11'(row_now * tcw_pkg::COLUMNS + col_now)] = {attr_reg, w.char_code};
          col_now++;
          if (col_now >= tcw_pkg::COLUMNS) begin
            col_now = 0;
            row_now++;
          end
        end
        if (row_now >= tcw_pkg::ROWS) begin
          for (int i = 0; i < tcw_pkg::CELLS - tcw_pkg::COLUMNS; i++)
            shadow_cells[11'(i)] = shadow_cells[11'(i + tcw_pkg::COLUMNS)];
          for (int i = tcw_pkg::CELLS - tcw_pkg::COLUMNS; i < tcw_pkg::CELLS; i++)
            shadow_cells[11'(i)] = blank;
          row_now = tcw_pkg::ROWS - 1;
          col_now = 0;
          r.scrolled = 1'b1;
        end
      end
      tcw_pkg::OP_CLEAR: begin
        for (int i = 0; i < tcw_pkg::CELLS; i++) shadow_cells[11'(i)] = blank;
        row_now = 0;
        col_now = 0;
      end
      tcw_pkg::OP_READ: begin
        if (w.cell_index < tcw_pkg::CELLS) r.cell_data = shadow_cells[w.cell_index];
      end
      default: ;
    endcase
    pos = row_now * tcw_pkg::COLUMNS + col_now;
    r.cursor_position = pos[10:0];
    return r;
  endfunction

  task automatic send_word(input tcw_pkg::in_word_t w);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    expected_words.push_back(console_result(w));
    burst_left--;
  endtask

  task automatic stop_input();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic write_attribute(input logic [7:0] value);
    stop_input();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    attr_reg = value;
  endtask

  always @(negedge clk) begin
    stall_mode_t mode;
    stall_tick++;
    mode = stall_mode_t'((stall_tick / 300) % 4);
    case (mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_COIN:   out_stall <= 1'($urandom_range(0, 1));
      STALL_RHYTHM: out_stall <= (stall_tick % 3 != 0);
      default:      out_stall <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    tcw_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, out_data);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        if (out_data.cursor_position !== want.cursor_position) begin
          $display("%0t: cursor_position expected %0d actual %0d", $time,
                   want.cursor_position, out_data.cursor_position);
          mismatches++;
        end
        if (out_data.cell_data !== want.cell_data) begin
          $display("%0t: cell_data expected %h actual %h", $time,
                   want.cell_data, out_data.cell_data);
          mismatches++;
        end
        if (out_data.scrolled !== want.scrolled) begin
          $display("%0t: scrolled expected %b actual %b", $time,
                   want.scrolled, out_data.scrolled);
          mismatches++;
        end
      end
    end
  end

  task automatic test_edge_words();
    send_word(make_word(tcw_pkg::OP_READ, 8'h00, 11'd0));
    send_word(make_word(tcw_pkg::OP_READ, 8'hFF, 11'(tcw_pkg::CELLS - 1)));
    send_word(make_word(tcw_pkg::OP_READ, 8'h00, 11'(tcw_pkg::CELLS)));
    send_word(make_word(tcw_pkg::OP_READ, 8'h00, 11'h7FF));
    send_word(make_word(tcw_pkg::OP_PUT, 8'h00, 11'h7FF));
    send_word(make_word(tcw_pkg::OP_PUT, 8'hFF, 11'd0));
    send_word(make_word(tcw_pkg::OP_PUT, 8'h7F, 11'd0));
    send_word(make_word(tcw_pkg::OP_PUT, 8'h80, 11'd0));
    send_word(make_word(tcw_pkg::OP_PUT, tcw_pkg::CH_RETURN, 11'd0));
    send_word(make_word(tcw_pkg::OP_PUT, 8'h41, 11'd0));
    send_word(make_word(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE, 11'd0));
    send_word(make_word(tcw_pkg::OP_PUT, tcw_pkg::CH_SPACE, 11'd0));
    for (int i = 0; i < 4; i++) send_word(make_word(tcw_pkg::OP_READ, 8'h00, 11'(i)));
    send_word(make_word(tcw_pkg::OP_READ, 8'h00, 11'(tcw_pkg::COLUMNS)));
    send_word(make_word(OP_UNUSED, 8'hFF, 11'h7FF));
    send_word(make_word(OP_UNUSED, 8'h00, 11'd0));
  endtask

  task automatic test_clear_blank();
    write_attribute(8'hFF);
    send_word(make_word(tcw_pkg::OP_PUT, 8'h5A, 11'd0));
    send_word(make_word(tcw_pkg::OP_CLEAR, 8'hFF, 11'h7FF));
    send_word(make_word(tcw_pkg::OP_READ, 8'h00, 11'd0));
    send_word(make_word(tcw_pkg::OP_READ, 8'h00, 11'(tcw_pkg::CELLS - 1)));
    write_attribute(8'h00);
    send_word(make_word(tcw_pkg::OP_PUT, 8'hC3, 11'd0));
    send_word(make_word(tcw_pkg::OP_CLEAR, 8'h00, 11'd0));
    send_word(make_word(tcw_pkg::OP_READ, 8'h00, 11'd1));
  endtask

  task automatic test_random_text(input int n_items);
    int sent;
    int pick;
    int len;
    int idx;
    logic [7:0] ch;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 12);
        for (int i = 0; i < len; i++) begin
          ch = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(32, 126));
          send_word(make_word(tcw_pkg::OP_PUT, ch,
                              11'($urandom_range(0, ADDR_SPAN - 1))));
        end
        sent += len;
        case ($urandom_range(0, 9))
          0: ;
          1: begin
            send_word(make_word(tcw_pkg::OP_PUT, tcw_pkg::CH_RETURN, '0));
            sent++;
          end
          2: begin
            send_word(make_word(tcw_pkg::OP_PUT, tcw_pkg::CH_RETURN, '0));
            send_word(make_word(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE, '0));
            sent += 2;
          end
          default: begin
            send_word(make_word(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE, '0));
            sent++;
          end
        endcase
      end else if (pick < 90) begin
        case ($urandom_range(0, 6))
          0, 1, 2: begin
            idx = row_now * tcw_pkg::COLUMNS + col_now - $urandom_range(0, 160);
            if (idx < 0) idx = 0;
          end
          3, 4, 5: idx = $urandom_range(0, tcw_pkg::CELLS - 1);
          default: idx = $urandom_range(tcw_pkg::CELLS, ADDR_SPAN - 1);
        endcase
        send_word(make_word(tcw_pkg::OP_READ, 8'($urandom_range(0, 255)), 11'(idx)));
        sent++;
      end else if (pick < 91) begin
        send_word(make_word(tcw_pkg::OP_CLEAR, 8'($urandom_range(0, 255)),
                            11'($urandom_range(0, ADDR_SPAN - 1))));
        sent++;
      end else if (pick < 95) begin
        send_word(make_word(OP_UNUSED, 8'($urandom_range(0, 255)),
                            11'($urandom_range(0, ADDR_SPAN - 1))));
        sent++;
      end else begin
        idx = row_now * tcw_pkg::COLUMNS;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
          send_word(make_word(tcw_pkg::OP_READ, '0,
                              11'(idx + $urandom_range(0, tcw_pkg::COLUMNS - 1))));
        sent += len;
      end
    end
  endtask

  initial begin
    int waited;
    attr_reg = tcw_pkg::ATTR_RESET;
    row_now = 0;
    col_now = 0;
    for (int i = 0; i < tcw_pkg::CELLS; i++)
      shadow_cells[11'(i)] = {tcw_pkg::ATTR_RESET, tcw_pkg::CH_SPACE};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_edge_words();
    test_clear_blank();
    write_attribute(8'h1F);
    test_random_text(230);
    write_attribute(8'($urandom_range(0, 255)));
    test_random_text(230);
    write_attribute(8'hFF);
    test_random_text(230);
    write_attribute(tcw_pkg::ATTR_RESET);
    test_random_text(230);

    stop_input();
    waited = 0;
    while (expected_words.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_words.size() != 0) begin
      $display("%0t: %0d result words never arrived, next expected %h", $time,
               expected_words.size(), expected_words[0]);
      mismatches++;
    end
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_front.sv
rtl/tcw_queue.sv
rtl/tcw_back.sv
rtl/text_console_writer_unit.sv
rtl/tcw_checker.sv
test/tb.sv
